[design/bthin_pkg.sv]
`default_nettype none
package bthin_pkg;

   // store geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS  = ROW_BITS + COL_BITS;

   // raster scan: one pad column per row, window line holds two rows plus three
   localparam int LINE_PERIOD = MAX_WIDTH + 1;
   localparam int LINE_LEN    = 2 * LINE_PERIOD + 3;

   // request function codes
   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_THIN = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;
   localparam logic [1:0] FUNC_NOP  = 2'd3;

   // response pixel values
   localparam logic [7:0] PIXEL_ON  = 8'd255;
   localparam logic [7:0] PIXEL_OFF = 8'd0;

   // classified request between front and back
   typedef struct packed {
      logic [1:0]           func;
      logic [ADDR_BITS-1:0] addr;
      logic                 in_store;
      logic                 pix;
   } cmd_type;

endpackage
`default_nettype wire

[design/bthin_front.sv]
`default_nettype none
module bthin_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [1:0]        req_func,
   input  wire logic [7:0]        req_row,
   input  wire logic [7:0]        req_col,
   input  wire logic              req_pixel_in,
   output logic                   cmd_valid,
   output bthin_pkg::cmd_type     cmd,
   input  wire logic              cmd_pop
);
   import bthin_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    new_cmd;
   logic       accept;
   logic       take;

   // classify the incoming request
   always_comb begin
      new_cmd.func     = req_func;
      new_cmd.addr     = {ROW_BITS'(req_row), COL_BITS'(req_col)};
      new_cmd.in_store = (32'(req_row) < MAX_HEIGHT) && (32'(req_col) < MAX_WIDTH);
      new_cmd.pix      = req_pixel_in;
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign accept    = req_push && !req_full;
   assign take      = cmd_pop && cmd_valid;

   // queue pointers
   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

[design/bthin_rspq.sv]
`default_nettype none
module bthin_rspq (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [7:0] push_data,
   output logic            full,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_pixel_out
);
   import bthin_pkg::*;

   logic [7:0] data_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       put, take;

   assign full          = (cnt_ff == 2'd2);
   assign rsp_empty     = (cnt_ff == 2'd0);
   assign rsp_pixel_out = data_ff[rd_ptr_ff];
   assign put           = push && !full;
   assign take          = rsp_pop && !rsp_empty;
   assign cnt_in        = cnt_ff + {1'b0, put} - {1'b0, take};

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (put) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (take) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (put) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[design/bthin_back.sv]
`default_nettype none
module bthin_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata,
   input  wire logic               cmd_valid,
   input  wire bthin_pkg::cmd_type cmd,
   output logic                    cmd_pop,
   input  wire logic               rsp_full,
   output logic                    rsp_push,
   output logic [7:0]              rsp_data
);
   import bthin_pkg::*;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_LIMIT  = 2'd2;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;

   localparam logic [COL_BITS:0] LAST_COL = (COL_BITS+1)'(MAX_WIDTH);

   // configuration
   logic [8:0]  width_ff, height_ff;
   logic [15:0] limit_ff;

   // control
   logic [2:0]  state_ff, state_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        pass_ff, pass_in;
   logic        any_ff, any_in;
   logic        rd_inside_ff, rd_inside_in;
   logic [ROW_BITS:0] r_ff, r_in;
   logic [COL_BITS:0] c_ff, c_in;
   logic        line_clear;

   // scan pipeline
   logic              s1_v_ff, s1_en_ff, s2_v_ff;
   logic [ROW_BITS:0] s1_r_ff, s2_r_ff;
   logic [COL_BITS:0] s1_c_ff, s2_c_ff;
   logic [LINE_LEN-1:0] line_ff;

   // image store
   logic img_mem [2**ADDR_BITS];
   logic mem_rd_ff;
   logic mem_we, mem_wd;
   logic [ADDR_BITS-1:0] mem_wa, mem_ra;

   logic [ROW_BITS:0] h_eff;
   logic [COL_BITS:0] w_eff;
   logic              scan_issue, px_en, scan_last;
   logic [16:0]       cnt_next;
   logic              stop;
   logic [7:0]        nb, nb_rot;
   logic [3:0]        nb_sum, nb_trans;
   logic              center, cen_ok, reject, del_we;
   logic [ADDR_BITS-1:0] del_addr;
   logic              load_we;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         limit_ff  <= 16'hFFFF;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata[8:0];
            CSR_HEIGHT: height_ff <= csr_wdata[8:0];
            CSR_LIMIT:  limit_ff  <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // area in use, clipped to the store
   assign h_eff = (32'(height_ff) > MAX_HEIGHT) ? (ROW_BITS+1)'(MAX_HEIGHT)
                                                : (ROW_BITS+1)'(height_ff);
   assign w_eff = (32'(width_ff) > MAX_WIDTH) ? (COL_BITS+1)'(MAX_WIDTH)
                                              : (COL_BITS+1)'(width_ff);

   // round limit check; only -1 runs without bound
   assign cnt_next = {1'b0, cnt_ff} + 17'd1;
   always_comb begin
      if (limit_ff[15]) begin
         stop = (limit_ff != 16'hFFFF);
      end else begin
         stop = (cnt_next > {1'b0, limit_ff});
      end
   end

   // raster scan position
   assign scan_issue = (state_ff == S_SCAN);
   assign px_en      = (r_ff < h_eff) && (c_ff < w_eff);
   assign scan_last  = (r_ff == h_eff) && (c_ff == LAST_COL);

   // neighbourhood window: ring P2..P9 around the center tap
   always_comb begin
      center  = line_ff[LINE_PERIOD+1];
      nb[0]   = line_ff[2*LINE_PERIOD+1];
      nb[1]   = line_ff[2*LINE_PERIOD];
      nb[2]   = line_ff[LINE_PERIOD];
      nb[3]   = line_ff[0];
      nb[4]   = line_ff[1];
      nb[5]   = line_ff[2];
      nb[6]   = line_ff[LINE_PERIOD+2];
      nb[7]   = line_ff[2*LINE_PERIOD+2];
      nb_rot  = {nb[0], nb[7:1]};
      nb_sum  = 4'($countones(nb));
      nb_trans = 4'($countones(~nb & nb_rot));
      if (!pass_ff) begin
         reject = (nb[0] & nb[2] & nb[4]) | (nb[2] & nb[4] & nb[6]);
      end else begin
         reject = (nb[0] & nb[2] & nb[6]) | (nb[0] & nb[4] & nb[6]);
      end
      cen_ok  = s2_v_ff && (s2_r_ff != '0) && (s2_c_ff != '0) && (s2_c_ff <= w_eff);
      del_we  = cen_ok && center && (nb_sum >= 4'd2) && (nb_sum <= 4'd6)
                && (nb_trans == 4'd1) && !reject;
      del_addr = {ROW_BITS'(s2_r_ff - 1'b1), COL_BITS'(s2_c_ff - 1'b1)};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      any_in       = any_ff | del_we;
      rd_inside_in = rd_inside_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      line_clear   = 1'b0;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp_data     = PIXEL_OFF;
      load_we      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               case (cmd.func)
                  FUNC_LOAD: begin
                     load_we  = cmd.in_store;
                     rsp_push = 1'b1;
                  end
                  FUNC_READ: begin
                     rd_inside_in = cmd.in_store;
                     state_in     = S_READ;
                  end
                  FUNC_THIN: begin
                     if (w_eff == '0 || h_eff == '0) begin
                        rsp_push = 1'b1;
                     end else begin
                        cnt_in   = 16'd0;
                        state_in = S_ROUND;
                     end
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_push = 1'b1;
            rsp_data = (rd_inside_ff && mem_rd_ff) ? PIXEL_ON : PIXEL_OFF;
            state_in = S_IDLE;
         end
         S_ROUND: begin
            if (stop) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end else begin
               if (cnt_ff != 16'hFFFF) begin
                  cnt_in = cnt_next[15:0];
               end
               pass_in    = 1'b0;
               any_in     = 1'b0;
               r_in       = '0;
               c_in       = '0;
               line_clear = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_last) begin
               state_in = S_DRAIN;
            end else if (c_ff == LAST_COL) begin
               c_in = '0;
               r_in = r_ff + 1'b1;
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               if (!any_ff) begin
                  rsp_push = 1'b1;
                  state_in = S_IDLE;
               end else if (!pass_ff) begin
                  pass_in    = 1'b1;
                  any_in     = 1'b0;
                  r_in       = '0;
                  c_in       = '0;
                  line_clear = 1'b1;
                  state_in   = S_SCAN;
               end else begin
                  state_in = S_ROUND;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         s1_v_ff  <= scan_issue;
         s2_v_ff  <= s1_v_ff;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      pass_ff      <= pass_in;
      any_ff       <= any_in;
      rd_inside_ff <= rd_inside_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      s1_en_ff     <= px_en;
      s1_r_ff      <= r_ff;
      s1_c_ff      <= c_ff;
      s2_r_ff      <= s1_r_ff;
      s2_c_ff      <= s1_c_ff;
      if (line_clear) begin
         line_ff <= '0;
      end else if (s1_v_ff) begin
         line_ff <= {line_ff[LINE_LEN-2:0], s1_en_ff & mem_rd_ff};
      end
   end

   // store ports
   assign mem_we = del_we | load_we;
   assign mem_wd = del_we ? 1'b0 : cmd.pix;
   assign mem_wa = del_we ? del_addr : cmd.addr;
   assign mem_ra = scan_issue ? {ROW_BITS'(r_ff), COL_BITS'(c_ff)} : cmd.addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         img_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= img_mem[mem_ra];
   end

   // checks
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("response pushed into full queue");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> rsp_push)
      else $error("read did not answer");

   a_delete_in_scan: assert property (@(posedge clock) disable iff (reset)
      del_we |-> (state_ff == S_SCAN || state_ff == S_DRAIN))
      else $error("deletion outside scan");

endmodule
`default_nettype wire

[design/binary_image_thinning.sv]
`default_nettype none
// channel   direction  handshake               payload
// req_      in         req_push / req_full     req_func, req_row, req_col, req_pixel_in
// rsp_      out        rsp_pop / rsp_empty     rsp_pixel_out
// csr_      in         csr_we                  csr_index, csr_wdata
//
// load is answered from the idle state and read from S_READ in the back end; requests queue
// two deep in front. each thin subpass walks (h+1)*(MAX_WIDTH+1) positions in raster
// order through the single read port of the image store; rounds run until stable or past
// the round limit.
// reset is synchronous, active high; it clears the queues and the configuration.
// the image store is not cleared: pixels hold nothing defined until loaded.
module binary_image_thinning (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_row,
   input  wire logic [7:0]  req_col,
   input  wire logic        req_pixel_in,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_pixel_out,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import bthin_pkg::*;

   logic       cmd_valid, cmd_pop;
   cmd_type    cmd;
   logic       rq_full, rq_push;
   logic [7:0] rq_data;

   // request queue and classification
   bthin_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_func     (req_func),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_pixel_in (req_pixel_in),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   // execution, image store and thinning engine
   bthin_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rq_full),
      .rsp_push  (rq_push),
      .rsp_data  (rq_data)
   );

   // response queue
   bthin_rspq u_rspq (
      .clock         (clock),
      .reset         (reset),
      .push          (rq_push),
      .push_data     (rq_data),
      .full          (rq_full),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_out (rsp_pixel_out)
   );

endmodule
`default_nettype wire
